### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion helper macros, used by hspl_back.
// They expect a clock named clk and an active-low reset named rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/hspl_pkg.sv
// ---------------------------------------------------------------------------
// hspl_pkg
// Shared types and constants of the HTTP status line parser.
// ---------------------------------------------------------------------------
package hspl_pkg;

    localparam int POS_BITS_DEF  = 16;
    localparam int OFS_BITS      = 16;
    localparam int CODE_BITS     = 10;
    localparam int BYTE_BITS     = 8;
    localparam int VERDICT_BITS  = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int STATUS_DIGITS = 3;

    localparam logic [VERDICT_BITS-1:0] VERDICT_MORE  = 2'd0;
    localparam logic [VERDICT_BITS-1:0] VERDICT_ERROR = 2'd1;
    localparam logic [VERDICT_BITS-1:0] VERDICT_DONE  = 2'd2;

    localparam logic [BYTE_BITS-1:0] CH_H      = 8'h48;
    localparam logic [BYTE_BITS-1:0] CH_T      = 8'h54;
    localparam logic [BYTE_BITS-1:0] CH_P      = 8'h50;
    localparam logic [BYTE_BITS-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_BITS-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_BITS-1:0] CH_ONE    = 8'h31;
    localparam logic [BYTE_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_BITS-1:0] CH_CR_ALT = 8'd129;
    localparam logic [BYTE_BITS-1:0] CH_LF_ALT = 8'd128;

    // Decoded byte, as handed from the front end to the parser.
    typedef struct packed {
        logic       is_h;
        logic       is_t;
        logic       is_p;
        logic       is_slash;
        logic       is_dot;
        logic       is_space;
        logic       is_cr;
        logic       is_lf;
        logic       is_digit;
        logic       is_nz_digit;
        logic [3:0] digit_val;
    } byte_class_t;

endpackage

### hw/rtl/hspl_front.sv
// ---------------------------------------------------------------------------
// hspl_front
// Input stage: takes one byte per transaction, repairs the masked line-end
// codes and registers the decoded byte class for the queue.
// ---------------------------------------------------------------------------
module hspl_front
    import hspl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  logic [BYTE_BITS-1:0] byte_req,
    output logic                 push,
    output byte_class_t          push_data,
    input  logic                 q_full
);

    logic                 f_valid_reg;
    logic                 f_valid_next;
    byte_class_t          f_class_reg;
    byte_class_t          f_class_next;
    logic [BYTE_BITS-1:0] b;
    logic                 accept;

    always_comb
    begin
        if (byte_req == CH_CR_ALT)
        begin
            b = CH_CR;
        end
        else if (byte_req == CH_LF_ALT)
        begin
            b = CH_LF;
        end
        else
        begin
            b = byte_req;
        end

        f_class_next.is_h        = (b == CH_H);
        f_class_next.is_t        = (b == CH_T);
        f_class_next.is_p        = (b == CH_P);
        f_class_next.is_slash    = (b == CH_SLASH);
        f_class_next.is_dot      = (b == CH_DOT);
        f_class_next.is_space    = (b == CH_SPACE);
        f_class_next.is_cr       = (b == CH_CR);
        f_class_next.is_lf       = (b == CH_LF);
        f_class_next.is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
        f_class_next.is_nz_digit = (b >= CH_ONE) && (b <= CH_NINE);
        f_class_next.digit_val   = b[3:0];
    end

    assign push       = f_valid_reg && !q_full;
    assign byte_stall = f_valid_reg && q_full;
    assign accept     = byte_valid && !byte_stall;
    assign push_data  = f_class_reg;

    always_comb
    begin
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
        else
        begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_class_reg <= f_class_next;
        end
    end

endmodule

### hw/rtl/hspl_fifo.sv
// ---------------------------------------------------------------------------
// hspl_fifo
// Short register queue of decoded bytes between front end and parser.
// ---------------------------------------------------------------------------
module hspl_fifo
    import hspl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  byte_class_t push_data,
    output logic        q_full,
    input  logic        pop,
    output logic        q_valid,
    output byte_class_t q_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    byte_class_t      entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/hspl_back.sv
// ---------------------------------------------------------------------------
// hspl_back
// Parser state machine: consumes decoded bytes from the queue, tracks line
// offsets and the status code, and holds the result in an output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hspl_back
    import hspl_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  byte_class_t             q_data,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [VERDICT_BITS-1:0] verdict,
    output logic [CODE_BITS-1:0]    status_code,
    output logic [OFS_BITS-1:0]     text_start,
    output logic [OFS_BITS-1:0]     text_end
);

    localparam int MUL_W = CODE_BITS + 4;

    typedef enum logic [3:0] {
        ST_START,
        ST_H,
        ST_HT,
        ST_HTT,
        ST_HTTP,
        ST_MAJ_FIRST,
        ST_MAJ,
        ST_MIN_FIRST,
        ST_MIN,
        ST_STATUS,
        ST_AFTER_STATUS,
        ST_TEXT,
        ST_ALMOST
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CODE_BITS-1:0]    acc_reg;
    logic [CODE_BITS-1:0]    acc_next;
    logic [1:0]              dc_reg;
    logic [1:0]              dc_next;
    logic [POS_BITS-1:0]     pos_reg;
    logic [POS_BITS-1:0]     start_reg;
    logic [POS_BITS-1:0]     start_next;
    logic [POS_BITS-1:0]     end_reg;
    logic [POS_BITS-1:0]     end_next;
    logic                    seen_reg;
    logic                    seen_next;
    logic [VERDICT_BITS-1:0] verdict_next;
    logic [MUL_W-1:0]        acc_x10;
    logic                    out_valid_reg;
    logic [VERDICT_BITS-1:0] verdict_reg;
    logic [CODE_BITS-1:0]    status_code_reg;
    logic [OFS_BITS-1:0]     text_start_reg;
    logic [OFS_BITS-1:0]     text_end_reg;
    byte_class_t             c;

    assign c   = q_data;
    assign pop = q_valid && (!out_valid_reg || !result_stall);

    assign result_valid = out_valid_reg;
    assign verdict      = verdict_reg;
    assign status_code  = status_code_reg;
    assign text_start   = text_start_reg;
    assign text_end     = text_end_reg;

    // acc * 10 + digit, kept to the low CODE_BITS
    assign acc_x10 = (MUL_W'(acc_reg) << 3) + (MUL_W'(acc_reg) << 1) + MUL_W'(c.digit_val);

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        dc_next      = dc_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        seen_next    = seen_reg;
        verdict_next = VERDICT_MORE;

        case (state_reg)
            ST_START:
            begin
                if (c.is_h) state_next = ST_H; else verdict_next = VERDICT_ERROR;
            end
            ST_H:
            begin
                if (c.is_t) state_next = ST_HT; else verdict_next = VERDICT_ERROR;
            end
            ST_HT:
            begin
                if (c.is_t) state_next = ST_HTT; else verdict_next = VERDICT_ERROR;
            end
            ST_HTT:
            begin
                if (c.is_p) state_next = ST_HTTP; else verdict_next = VERDICT_ERROR;
            end
            ST_HTTP:
            begin
                if (c.is_slash) state_next = ST_MAJ_FIRST; else verdict_next = VERDICT_ERROR;
            end
            ST_MAJ_FIRST:
            begin
                if (c.is_nz_digit) state_next = ST_MAJ; else verdict_next = VERDICT_ERROR;
            end
            ST_MAJ:
            begin
                if (c.is_dot)
                begin
                    state_next = ST_MIN_FIRST;
                end
                else if (!c.is_digit)
                begin
                    verdict_next = VERDICT_ERROR;
                end
            end
            ST_MIN_FIRST:
            begin
                if (c.is_digit) state_next = ST_MIN; else verdict_next = VERDICT_ERROR;
            end
            ST_MIN:
            begin
                if (c.is_space)
                begin
                    state_next = ST_STATUS;
                end
                else if (!c.is_digit)
                begin
                    verdict_next = VERDICT_ERROR;
                end
            end
            ST_STATUS:
            begin
                // spaces among the status digits are skipped
                if (!c.is_space)
                begin
                    if (!c.is_digit)
                    begin
                        verdict_next = VERDICT_ERROR;
                    end
                    else
                    begin
                        if (dc_reg == 2'd0)
                        begin
                            start_next = pos_reg;
                        end
                        acc_next = acc_x10[CODE_BITS-1:0];
                        dc_next  = dc_reg + 2'd1;
                        if (dc_next == 2'(STATUS_DIGITS))
                        begin
                            state_next = ST_AFTER_STATUS;
                        end
                    end
                end
            end
            ST_AFTER_STATUS:
            begin
                if (c.is_space || c.is_dot)
                begin
                    state_next = ST_TEXT;
                end
                else if (c.is_cr)
                begin
                    state_next = ST_ALMOST;
                end
                else if (c.is_lf)
                begin
                    verdict_next = VERDICT_DONE;
                end
                else
                begin
                    verdict_next = VERDICT_ERROR;
                end
            end
            ST_TEXT:
            begin
                if (c.is_cr)
                begin
                    state_next = ST_ALMOST;
                end
                else if (c.is_lf)
                begin
                    verdict_next = VERDICT_DONE;
                end
            end
            ST_ALMOST:
            begin
                // CR sat one byte back
                end_next  = pos_reg - 1'b1;
                seen_next = 1'b1;
                if (c.is_lf) verdict_next = VERDICT_DONE; else verdict_next = VERDICT_ERROR;
            end
            default:
            begin
                verdict_next = VERDICT_ERROR;
            end
        endcase

        // bare LF: end offset is the LF itself
        if ((verdict_next == VERDICT_DONE) && !seen_next)
        begin
            end_next  = pos_reg;
            seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_START;
            acc_reg         <= '0;
            dc_reg          <= '0;
            pos_reg         <= '0;
            start_reg       <= '0;
            end_reg         <= '0;
            seen_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            verdict_reg     <= VERDICT_MORE;
            status_code_reg <= '0;
            text_start_reg  <= '0;
            text_end_reg    <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg   <= 1'b1;
                verdict_reg     <= verdict_next;
                status_code_reg <= acc_next;
                text_start_reg  <= OFS_BITS'(start_next);
                text_end_reg    <= OFS_BITS'(end_next);
                if (verdict_next != VERDICT_MORE)
                begin
                    state_reg <= ST_START;
                    acc_reg   <= '0;
                    dc_reg    <= '0;
                    pos_reg   <= '0;
                    start_reg <= '0;
                    end_reg   <= '0;
                    seen_reg  <= 1'b0;
                end
                else
                begin
                    state_reg <= state_next;
                    acc_reg   <= acc_next;
                    dc_reg    <= dc_next;
                    pos_reg   <= pos_reg + 1'b1;
                    start_reg <= start_next;
                    end_reg   <= end_next;
                    seen_reg  <= seen_next;
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_NEXT(a_clear_after_verdict, pop && (verdict_next != VERDICT_MORE),
                 (state_reg == ST_START) && (pos_reg == '0) && !seen_reg)
    `ASSERT_SAME(a_digits_complete,
                 (state_reg == ST_AFTER_STATUS) || (state_reg == ST_TEXT) ||
                 (state_reg == ST_ALMOST),
                 dc_reg == 2'(STATUS_DIGITS))
    `ASSERT_SAME(a_done_has_end, pop && (verdict_next == VERDICT_DONE), seen_next)

endmodule

### hw/rtl/http_status_line_parser.sv
// Path: an accepted byte passes the front-end register, a queue entry and the output register before result_valid.
// Throughput: one byte per cycle while the output is not stalled, set by the parser state machine.
// The two-entry queue lets the front end keep taking bytes while the output is stalled.
// Reset: asynchronous, clears the parser to the start of a line and empties all stages.
// ---------------------------------------------------------------------------
// http_status_line_parser
// Byte-serial recognizer of an HTTP response status line with per-byte verdict.
// ---------------------------------------------------------------------------
module http_status_line_parser
    import hspl_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_stall,
    input  logic [BYTE_BITS-1:0]    byte_req,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [VERDICT_BITS-1:0] verdict,
    output logic [CODE_BITS-1:0]    status_code,
    output logic [OFS_BITS-1:0]     text_start,
    output logic [OFS_BITS-1:0]     text_end
);

    logic        push;
    byte_class_t push_data;
    logic        q_full;
    logic        pop;
    logic        q_valid;
    byte_class_t q_data;

    hspl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_req   (byte_req),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    hspl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    hspl_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .verdict      (verdict),
        .status_code  (status_code),
        .text_start   (text_start),
        .text_end     (text_end)
    );

endmodule
